// ----- sv/priority_ready_queue_macros.svh -----
// ----------------------------------------------------------------------------
// priority_ready_queue_macros
// Assertion macros used by the ready queue RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH

// Generic clocked assertion with an explicit disable condition.
`define PRQ_PROP(label, dis, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (dis) prop) else $error(msg);

// Assertion that is off while the block is held in reset.
`define PRQ_ASSERT(label, prop, msg) \
    `PRQ_PROP(label, !aresetn, prop, msg)

`endif

// ----- sv/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Types, codes and helpers of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Fixed field widths of the stream words.
    localparam int OPCODE_W = 2;
    localparam int TASK_FIELD_W = 6;
    localparam int PRIO_FIELD_W = 5;
    localparam int STATUS_W = 3;
    localparam int LEVELS_MAX = 32;
    localparam int IN_WORD_W = 16;
    localparam int OUT_WORD_W = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POP     = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_PEEK    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_ALREADY    = 3'd2,
        STAT_NOT_QUEUED = 3'd3,
        STAT_BAD_PRIO   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UNLINK
    } state_t;

    // Index of the lowest set bit, zero when no bit is set.
    function automatic logic [PRIO_FIELD_W-1:0] lowest_set(input logic [LEVELS_MAX-1:0] v);
        logic [PRIO_FIELD_W-1:0] r;
        r = '0;
        for (int i = LEVELS_MAX - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = PRIO_FIELD_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue
// Scheduler ready queue: one FIFO per priority level over per-task links.
// ----------------------------------------------------------------------------
// The queue handles one command word at a time and answers each with exactly
// one result word. Enqueue, peek and every rejected command pass through the
// accept cycle, which also issues the level RAM read, and the lookup state
// that writes back and loads the result. Pop and remove add an unlink state,
// because the second link read depends on the first (the head for pop, the
// task's level for remove). A result waits in the output register, so a
// stalled master only holds the block when a second result is ready before
// the first has been taken. No clearing pass follows reset: head, tail and
// link entries are only used after they were written.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_macros.svh"

module priority_ready_queue import prq_pkg::*; #(
    parameter int PRIORITY_LEVELS = 32,
    parameter int MAX_TASKS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Command: opcode[1:0], task_id[7:2], priority_req[12:8], zero [15:13].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_WORD_W-1:0]  s_tdata,
    // Result: status[2:0], result_task[8:3], task_valid[9],
    // best_level[14:10], all_empty[15].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_WORD_W-1:0] m_tdata
);

    localparam int LVL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int TASK_W = $clog2(MAX_TASKS);
    localparam int LVL_ENT_W = 2 * TASK_W;
    localparam int PRV_ENT_W = TASK_W + LVL_W;

    // Control and bookkeeping registers.
    state_t                     state_reg, state_next;
    opcode_t                    op_reg, op_next;
    status_t                    status_reg, status_next;
    logic [TASK_W-1:0]          tid_reg, tid_next;
    logic [TASK_FIELD_W-1:0]    tid_field_reg, tid_field_next;
    logic [LVL_W-1:0]           prio_reg, prio_next;
    logic [LVL_W-1:0]           lv_reg, lv_next;
    logic [TASK_W-1:0]          head_reg, head_next;
    logic [TASK_W-1:0]          tail_reg, tail_next;
    logic [TASK_W-1:0]          link_nx_reg, link_nx_next;
    logic [TASK_W-1:0]          link_pv_reg, link_pv_next;
    logic [PRIORITY_LEVELS-1:0] bitmap_reg, bitmap_next;
    logic [MAX_TASKS-1:0]       queued_reg, queued_next;
    logic                       m_tvalid_reg;
    logic [OUT_WORD_W-1:0]      m_tdata_reg;

    // Incoming command fields.
    opcode_t                 in_op;
    logic [TASK_FIELD_W-1:0] in_tid;
    logic [PRIO_FIELD_W-1:0] in_prio;
    logic [TASK_W-1:0]       in_tid_idx;
    logic [LVL_W-1:0]        in_prio_idx;
    logic [LVL_W-1:0]        best_idx;
    logic                    in_accept;
    logic                    out_free;

    // RAM ports.
    logic                 lvl_we, lvl_re;
    logic [LVL_W-1:0]     lvl_waddr, lvl_raddr;
    logic [LVL_ENT_W-1:0] lvl_wdata, lvl_rdata;
    logic                 nxt_we, nxt_re;
    logic [TASK_W-1:0]    nxt_waddr, nxt_raddr;
    logic [TASK_W-1:0]    nxt_wdata, nxt_rdata;
    logic                 prv_we, prv_re;
    logic [TASK_W-1:0]    prv_waddr, prv_raddr;
    logic [PRV_ENT_W-1:0] prv_wdata, prv_rdata;

    // Unlink view of the victim task.
    logic [TASK_W-1:0] ul_head, ul_tail, ul_nx, ul_pv;
    logic              ul_is_head, ul_is_tail;

    // Result word.
    logic                    out_load;
    status_t                 res_status;
    logic [TASK_FIELD_W-1:0] res_task;
    logic                    res_valid;
    logic [PRIO_FIELD_W-1:0] res_best;
    logic                    res_empty;

    assign in_op       = opcode_t'(s_tdata[1:0]);
    assign in_tid      = s_tdata[7:2];
    assign in_prio     = s_tdata[12:8];
    assign in_tid_idx  = TASK_W'(32'(in_tid));
    assign in_prio_idx = LVL_W'(in_prio);
    assign best_idx    = LVL_W'(lowest_set(LEVELS_MAX'(bitmap_reg)));

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Level RAM: {head, tail} per priority level.
    prq_ram #(.WIDTH(LVL_ENT_W), .DEPTH(PRIORITY_LEVELS)) u_lvl_ram (
        .aclk    (aclk),
        .wr_en   (lvl_we),
        .wr_addr (lvl_waddr),
        .wr_data (lvl_wdata),
        .rd_en   (lvl_re),
        .rd_addr (lvl_raddr),
        .rd_data (lvl_rdata)
    );

    // Next-link RAM: successor of each task within its level.
    prq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_nxt_ram (
        .aclk    (aclk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_en   (nxt_re),
        .rd_addr (nxt_raddr),
        .rd_data (nxt_rdata)
    );

    // Previous-link RAM: {predecessor, level} of each task.
    prq_ram #(.WIDTH(PRV_ENT_W), .DEPTH(MAX_TASKS)) u_prv_ram (
        .aclk    (aclk),
        .wr_en   (prv_we),
        .wr_addr (prv_waddr),
        .wr_data (prv_wdata),
        .rd_en   (prv_re),
        .rd_addr (prv_raddr),
        .rd_data (prv_rdata)
    );

    // Links of the task being unlinked. The next link of a tail and the previous
    // link of a head are never used; they follow from the level's head and tail.
    always_comb begin
        if (op_reg == OP_POP) begin
            ul_head = head_reg;
            ul_tail = tail_reg;
            ul_nx   = nxt_rdata;
        end else begin
            ul_head = lvl_rdata[LVL_ENT_W-1:TASK_W];
            ul_tail = lvl_rdata[TASK_W-1:0];
            ul_nx   = link_nx_reg;
        end
        ul_pv      = link_pv_reg;
        ul_is_head = (ul_head == tid_reg);
        ul_is_tail = (ul_tail == tid_reg);
    end

    // Sequencer: next state, RAM accesses and result.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        tid_next       = tid_reg;
        tid_field_next = tid_field_reg;
        prio_next      = prio_reg;
        lv_next        = lv_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        link_nx_next   = link_nx_reg;
        link_pv_next   = link_pv_reg;
        bitmap_next    = bitmap_reg;
        queued_next    = queued_reg;

        lvl_re    = 1'b0;
        lvl_raddr = (in_op == OP_ENQUEUE) ? in_prio_idx : best_idx;
        nxt_re    = 1'b0;
        nxt_raddr = in_tid_idx;
        prv_re    = 1'b0;
        prv_raddr = in_tid_idx;
        lvl_we    = 1'b0;
        lvl_waddr = lv_reg;
        lvl_wdata = '0;
        nxt_we    = 1'b0;
        nxt_waddr = '0;
        nxt_wdata = '0;
        prv_we    = 1'b0;
        prv_waddr = '0;
        prv_wdata = '0;

        out_load   = 1'b0;
        res_status = status_reg;
        res_task   = '0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // Accept a command, check it and start the first reads.
                if (in_accept) begin
                    lvl_re         = 1'b1;
                    nxt_re         = 1'b1;
                    prv_re         = 1'b1;
                    op_next        = in_op;
                    tid_next       = in_tid_idx;
                    tid_field_next = in_tid;
                    prio_next      = in_prio_idx;
                    lv_next        = best_idx;
                    state_next     = ST_LOOKUP;
                    unique case (in_op)
                        OP_ENQUEUE: begin
                            if (32'(in_tid) >= MAX_TASKS) begin
                                status_next = STAT_NOT_QUEUED;
                            end else if (queued_reg[in_tid_idx]) begin
                                status_next = STAT_ALREADY;
                            end else if (32'(in_prio) >= PRIORITY_LEVELS) begin
                                status_next = STAT_BAD_PRIO;
                            end else begin
                                status_next = STAT_OK;
                            end
                        end
                        OP_REMOVE: begin
                            if (32'(in_tid) >= MAX_TASKS || !queued_reg[in_tid_idx]) begin
                                status_next = STAT_NOT_QUEUED;
                            end else begin
                                status_next = STAT_OK;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            status_next = (bitmap_reg == '0) ? STAT_EMPTY : STAT_OK;
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_LOOKUP: begin
                if (status_reg != STAT_OK) begin
                    // Rejected command: report it and change nothing.
                    if (out_free) begin
                        out_load   = 1'b1;
                        res_task   = (op_reg == OP_ENQUEUE || op_reg == OP_REMOVE)
                                   ? tid_field_reg : '0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    unique case (op_reg)
                        OP_ENQUEUE: begin
                            // Append at the tail of the level.
                            if (out_free) begin
                                lvl_we    = 1'b1;
                                lvl_waddr = prio_reg;
                                lvl_wdata = bitmap_reg[prio_reg]
                                          ? {lvl_rdata[LVL_ENT_W-1:TASK_W], tid_reg}
                                          : {tid_reg, tid_reg};
                                prv_we    = 1'b1;
                                prv_waddr = tid_reg;
                                prv_wdata = {lvl_rdata[TASK_W-1:0], prio_reg};
                                nxt_we    = bitmap_reg[prio_reg];
                                nxt_waddr = lvl_rdata[TASK_W-1:0];
                                nxt_wdata = tid_reg;
                                queued_next[tid_reg] = 1'b1;
                                bitmap_next[prio_reg] = 1'b1;
                                out_load   = 1'b1;
                                res_task   = tid_field_reg;
                                res_valid  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        OP_PEEK: begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_task   = TASK_FIELD_W'(lvl_rdata[LVL_ENT_W-1:TASK_W]);
                                res_valid  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        OP_POP: begin
                            // The head is the victim; fetch its next link.
                            tid_next   = lvl_rdata[LVL_ENT_W-1:TASK_W];
                            head_next  = lvl_rdata[LVL_ENT_W-1:TASK_W];
                            tail_next  = lvl_rdata[TASK_W-1:0];
                            nxt_re     = 1'b1;
                            nxt_raddr  = lvl_rdata[LVL_ENT_W-1:TASK_W];
                            state_next = ST_UNLINK;
                        end
                        OP_REMOVE: begin
                            // Keep the task's links and fetch its level entry.
                            link_nx_next = nxt_rdata;
                            link_pv_next = prv_rdata[PRV_ENT_W-1:LVL_W];
                            lv_next      = prv_rdata[LVL_W-1:0];
                            lvl_re       = 1'b1;
                            lvl_raddr    = prv_rdata[LVL_W-1:0];
                            state_next   = ST_UNLINK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_UNLINK: begin
                // Splice the victim out of its level and write back.
                if (out_free) begin
                    nxt_we    = !ul_is_head;
                    nxt_waddr = ul_pv;
                    nxt_wdata = ul_nx;
                    prv_we    = !ul_is_tail;
                    prv_waddr = ul_nx;
                    prv_wdata = {ul_pv, lv_reg};
                    lvl_we    = ul_is_head ^ ul_is_tail;
                    lvl_waddr = lv_reg;
                    lvl_wdata = {ul_is_head ? ul_nx : ul_head, ul_is_tail ? ul_pv : ul_tail};
                    queued_next[tid_reg] = 1'b0;
                    if (ul_is_head && ul_is_tail) begin
                        bitmap_next[lv_reg] = 1'b0;
                    end
                    out_load   = 1'b1;
                    res_task   = TASK_FIELD_W'(tid_reg);
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Summary of the levels after the command.
    assign res_best  = lowest_set(LEVELS_MAX'(bitmap_next));
    assign res_empty = (bitmap_next == '0);

    // State and bookkeeping registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bitmap_reg   <= '0;
            queued_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bitmap_reg <= bitmap_next;
            queued_reg <= queued_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        tid_reg       <= tid_next;
        tid_field_reg <= tid_field_next;
        prio_reg      <= prio_next;
        lv_reg        <= lv_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        link_nx_reg   <= link_nx_next;
        link_pv_reg   <= link_pv_next;
        if (out_load) begin
            m_tdata_reg <= {res_empty, res_best, res_valid, res_task, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer and the queue bookkeeping.
    `PRQ_ASSERT(a_accept_busy, in_accept |=> (state_reg != ST_IDLE), "word not started")
    `PRQ_ASSERT(a_map_match, ((queued_reg == '0) == (bitmap_reg == '0)), "level map mismatch")
    `PRQ_ASSERT(a_load_free, out_load |-> (!m_tvalid_reg || m_tready), "pending word lost")
    `PRQ_ASSERT(a_unlink_op, (state_reg == ST_UNLINK) |-> (op_reg == OP_POP || op_reg == OP_REMOVE), "stray unlink")

endmodule

// ----- sv/prq_ram.sv -----
// ----------------------------------------------------------------------------
// prq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
